[rtl/disjoint_set_union_by_rank_macros.svh]
// assertion macros used by the checker file
`ifndef DISJOINT_SET_UNION_BY_RANK_MACROS_SVH
`define DISJOINT_SET_UNION_BY_RANK_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define DSU_ASSERT_IMP(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dsu check failed");

// next-cycle implication, disabled while reset is asserted
`define DSU_ASSERT_NXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dsu check failed");

`endif

[rtl/dsu_pkg.sv]
// ----------------------------------------------------------------------------
// dsu_pkg
// Types and constants of the union-find engine.
// ----------------------------------------------------------------------------
package dsu_pkg;

  localparam int unsigned SET_SIZE = 32;
  localparam int unsigned IDX_W    = (SET_SIZE > 1) ? $clog2(SET_SIZE) : 1;
  localparam int unsigned ELEM_W   = 5;
  localparam int unsigned FUNC_W   = 2;
  localparam int unsigned RANK_W   = 3;

  typedef logic [ELEM_W-1:0] elem_t;
  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [RANK_W-1:0] rank_t;

  localparam rank_t RANK_MAX = '1;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_CLEAR = 2'd0,
    FUNC_UNION = 2'd1,
    FUNC_QUERY = 2'd2
  } func_e;

  typedef struct packed {
    rank_t rank;
    idx_t  parent;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic   clr;
    logic   wr_en;
    idx_t   wr_addr;
    entry_t wr_data;
    idx_t   rd_addr;
  } tbl_req_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK_A,
    ST_WALK_B,
    ST_LINK,
    ST_BUMP,
    ST_DONE
  } state_e;

endpackage

[rtl/dsu_intf.sv]
// ----------------------------------------------------------------------------
// dsu_in_if / dsu_out_if
// Valid/ready channels for operation beats and result beats.
// ----------------------------------------------------------------------------
interface dsu_in_if
  import dsu_pkg::*;
;
  logic                valid;
  logic                ready;
  logic [FUNC_W-1:0]   func;
  elem_t               elem_a;
  elem_t               elem_b;

  modport source (output valid, func, elem_a, elem_b, input ready);
  modport sink   (input valid, func, elem_a, elem_b, output ready);
endinterface

interface dsu_out_if;
  logic valid;
  logic ready;
  logic same_set;

  modport source (output valid, same_set, input ready);
  modport sink   (input valid, same_set, output ready);
endinterface

[rtl/dsu_ram.sv]
// ----------------------------------------------------------------------------
// dsu_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module dsu_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                        wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/dsu_table.sv]
// ----------------------------------------------------------------------------
// dsu_table
// Parent/rank store with per-entry valid bits; an entry never written since
// the last clear reads as its own parent with rank zero.
// ----------------------------------------------------------------------------
module dsu_table
  import dsu_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  tbl_req_t req_i,
  output entry_t   rd_entry_o
);

  logic [SET_SIZE-1:0] valid_q;
  logic                rd_valid_q;
  idx_t                rd_addr_q;
  logic [ENTRY_W-1:0]  ram_rdata;
  entry_t              ram_entry;

  dsu_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (SET_SIZE)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (req_i.wr_en),
    .waddr_i (req_i.wr_addr),
    .wdata_i (req_i.wr_data),
    .raddr_i (req_i.rd_addr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
      rd_addr_q  <= '0;
    end else begin
      if (req_i.clr) begin
        valid_q <= '0;
      end else if (req_i.wr_en) begin
        valid_q[req_i.wr_addr] <= 1'b1;
      end
      rd_valid_q <= valid_q[req_i.rd_addr];
      rd_addr_q  <= req_i.rd_addr;
    end
  end

  assign ram_entry = entry_t'(ram_rdata);

  always_comb begin
    if (rd_valid_q) begin
      rd_entry_o = ram_entry;
    end else begin
      rd_entry_o.rank   = '0;
      rd_entry_o.parent = rd_addr_q;
    end
  end

endmodule

[rtl/dsu_ctrl.sv]
// ----------------------------------------------------------------------------
// dsu_ctrl
// Sequencer: walks both find chains through the table one read per cycle,
// then, for a union of two sets, links the roots by rank.
// ----------------------------------------------------------------------------
module dsu_ctrl
  import dsu_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  dsu_in_if.sink   in_i,
  output tbl_req_t tbl_req_o,
  input  entry_t   rd_entry_i,
  input  logic     out_free_i,
  output logic     done_o,
  output logic     same_o
);

  state_e state_q, state_d;
  logic   union_q, union_d;
  logic   same_q, same_d;
  idx_t   cur_q, cur_d;
  idx_t   b_q, b_d;
  idx_t   root_a_q, root_a_d;
  idx_t   root_b_q, root_b_d;
  rank_t  rank_a_q, rank_a_d;
  rank_t  rank_b_q, rank_b_d;
  logic   in_range;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    union_q  <= union_d;
    same_q   <= same_d;
    cur_q    <= cur_d;
    b_q      <= b_d;
    root_a_q <= root_a_d;
    root_b_q <= root_b_d;
    rank_a_q <= rank_a_d;
    rank_b_q <= rank_b_d;
  end

  assign in_range = (32'(in_i.elem_a) < SET_SIZE) && (32'(in_i.elem_b) < SET_SIZE);

  always_comb begin
    state_d   = state_q;
    union_d   = union_q;
    same_d    = same_q;
    cur_d     = cur_q;
    b_d       = b_q;
    root_a_d  = root_a_q;
    root_b_d  = root_b_q;
    rank_a_d  = rank_a_q;
    rank_b_d  = rank_b_q;
    tbl_req_o = '0;
    tbl_req_o.rd_addr = cur_q;
    in_i.ready = 1'b0;
    done_o     = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        in_i.ready        = 1'b1;
        tbl_req_o.rd_addr = IDX_W'(in_i.elem_a);
        if (in_i.valid) begin
          same_d  = 1'b0;
          state_d = ST_DONE;
          unique case (func_e'(in_i.func))
            FUNC_CLEAR: begin
              tbl_req_o.clr = 1'b1;
            end
            FUNC_UNION, FUNC_QUERY: begin
              if (in_range) begin
                union_d = (func_e'(in_i.func) == FUNC_UNION);
                cur_d   = IDX_W'(in_i.elem_a);
                b_d     = IDX_W'(in_i.elem_b);
                state_d = ST_WALK_A;
              end
            end
            default: begin
              state_d = ST_DONE;
            end
          endcase
        end
      end

      ST_WALK_A: begin
        if (rd_entry_i.parent == cur_q) begin
          root_a_d          = cur_q;
          rank_a_d          = rd_entry_i.rank;
          cur_d             = b_q;
          tbl_req_o.rd_addr = b_q;
          state_d           = ST_WALK_B;
        end else begin
          // follow the parent pointer, next read issued this cycle
          cur_d             = rd_entry_i.parent;
          tbl_req_o.rd_addr = rd_entry_i.parent;
        end
      end

      ST_WALK_B: begin
        if (rd_entry_i.parent == cur_q) begin
          root_b_d = cur_q;
          rank_b_d = rd_entry_i.rank;
          same_d   = (cur_q == root_a_q);
          state_d  = (union_q && (cur_q != root_a_q)) ? ST_LINK : ST_DONE;
        end else begin
          cur_d             = rd_entry_i.parent;
          tbl_req_o.rd_addr = rd_entry_i.parent;
        end
      end

      ST_LINK: begin
        tbl_req_o.wr_en = 1'b1;
        state_d         = ST_DONE;
        if (rank_a_q > rank_b_q) begin
          tbl_req_o.wr_addr        = root_b_q;
          tbl_req_o.wr_data.rank   = rank_b_q;
          tbl_req_o.wr_data.parent = root_a_q;
        end else begin
          tbl_req_o.wr_addr        = root_a_q;
          tbl_req_o.wr_data.rank   = rank_a_q;
          tbl_req_o.wr_data.parent = root_b_q;
          // equal ranks: second root grows, saturating
          if ((rank_a_q == rank_b_q) && (rank_b_q < RANK_MAX)) begin
            state_d = ST_BUMP;
          end
        end
      end

      ST_BUMP: begin
        tbl_req_o.wr_en          = 1'b1;
        tbl_req_o.wr_addr        = root_b_q;
        tbl_req_o.wr_data.rank   = rank_b_q + rank_t'(1);
        tbl_req_o.wr_data.parent = root_b_q;
        state_d                  = ST_DONE;
      end

      ST_DONE: begin
        if (out_free_i) begin
          done_o  = 1'b1;
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign same_o = same_q;

endmodule

[rtl/disjoint_set_union_by_rank.sv]
// ----------------------------------------------------------------------------
// disjoint_set_union_by_rank
// Union-find engine with union by rank over a table of SET_SIZE elements.
// ----------------------------------------------------------------------------
// clear, unused code or out-of-range index: straight to ST_DONE, result beat via the output register
// union/query: walk a, walk b, then for a union of two sets the link write in ST_LINK and a rank write in ST_BUMP
// one table read per cycle paces both find walks; depth is at most log2(SET_SIZE)
// next beat is taken once the result is in the output register
// reset: every element its own parent, rank zero (valid bits cleared at once)
module disjoint_set_union_by_rank
  import dsu_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  dsu_in_if.sink    in_i,
  dsu_out_if.source out_o
);

  tbl_req_t tbl_req;
  entry_t   rd_entry;
  logic     done;
  logic     same;
  logic     out_valid_q;
  logic     same_set_q;
  logic     out_free;

  assign out_free = !out_valid_q || out_o.ready;

  dsu_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_i),
    .tbl_req_o  (tbl_req),
    .rd_entry_i (rd_entry),
    .out_free_i (out_free),
    .done_o     (done),
    .same_o     (same)
  );

  dsu_table u_table (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (tbl_req),
    .rd_entry_o (rd_entry)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (done) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done) begin
      same_set_q <= same;
    end
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.same_set = same_set_q;

endmodule

[rtl/dsu_checker.sv]
// ----------------------------------------------------------------------------
// dsu_checker
// Port-level checks of the union-find engine, bound to the top level.
// ----------------------------------------------------------------------------
`include "disjoint_set_union_by_rank_macros.svh"

module dsu_checker
  import dsu_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_i,
  input logic [FUNC_W-1:0] in_func_i,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input logic              out_same_set_i
);

  `DSU_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i)
  `DSU_ASSERT_NXT(a_out_stable, clk_i, rst_ni, out_valid_i && !out_ready_i, $stable(out_same_set_i))
  // one operation at a time
  `DSU_ASSERT_NXT(a_busy_after_beat, clk_i, rst_ni, in_valid_i && in_ready_i, !in_ready_i)
  // clear answers with a zero result through ST_DONE and the output register when the output is free
  `DSU_ASSERT_IMP(a_clear_result, clk_i, rst_ni, in_valid_i && in_ready_i && (in_func_i == FUNC_CLEAR) && !out_valid_i, ##2 (out_valid_i && !out_same_set_i))

endmodule

bind disjoint_set_union_by_rank dsu_checker u_dsu_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_i.valid),
  .in_ready_i     (in_i.ready),
  .in_func_i      (in_i.func),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .out_same_set_i (out_o.same_set)
);
